### hdl/table_keyed_xor_stream_cipher_macros.svh
// Assertion macros for the table keyed XOR stream cipher checker
`ifndef TABLE_KEYED_XOR_STREAM_CIPHER_MACROS_SVH
`define TABLE_KEYED_XOR_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TKX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TKX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tkx_pkg.sv
// Shared types and constants of the table keyed XOR stream cipher
package tkx_pkg;

  localparam int KEY_W  = 7;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 12;
  localparam int TLEN_W = 13;
  localparam int CFG_W  = 13;
  localparam int CIDX_W = 1;

  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_KEY_WR   = 2'd1,
    CMD_TABLE_WR = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_e;

  localparam logic [CIDX_W-1:0] CFG_KEY_LENGTH   = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_TABLE_LENGTH = 1'b1;

endpackage

### hdl/tkx_ram.sv
// Generic single-write, single-read RAM with registered read data
module tkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tkx_mod_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle
module tkx_mod_unit #(
  parameter int W = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] rem_o,
  output logic         done_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvd_q;
  logic [W-1:0]  dvs_q;
  logic [W-1:0]  rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fits;

  assign trial = {rem_q, dvd_q[W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (dividend_i < divisor_i) begin
          rem_q  <= dividend_i;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rem_q  <= '0;
          dvd_q  <= dividend_i;
          dvs_q  <= divisor_i;
          cnt_q  <= CW'(W);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### hdl/table_keyed_xor_stream_cipher.sv
// Top level of the table keyed XOR stream cipher
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    command_i, entry_address_i, byte_value_i
//   out      source     out_valid_o / out_ready_i  cipher_byte_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Key write, table write and restart beats complete in the cycle they are accepted.
// A data beat runs three passes of the shared bit-serial remainder unit (DW bits, DW =
// max(log2 TABLE_DEPTH, 7) + 1) for key position, table position and table address,
// each cut short when its operand is below the length; a table read and output follow.
// in_ready_o is low while a data beat is in work; a result not yet taken stalls
// the last step. Reset clears positions and sets both lengths to one; the stores need no clear.
module table_keyed_xor_stream_cipher
  import tkx_pkg::*;
#(
  parameter int KEY_DEPTH   = 64,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [ADDR_W-1:0] entry_address_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] cipher_byte_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW  = ((TAW > KEY_W) ? TAW : KEY_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KMOD,
    ST_TMOD,
    ST_AMOD,
    ST_TRD,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [KAW-1:0]    key_pos_q;
  logic [TAW-1:0]    table_pos_q;
  logic [DW-1:0]     klen_q;
  logic [DW-1:0]     tlen_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] cipher_q;
  logic [BYTE_W-1:0] val_q;
  logic [KAW-1:0]    kpos_q;
  logic [TAW-1:0]    tpos_q;

  logic              in_acc;
  logic [31:0]       addr_ext;
  logic              key_we;
  logic              tab_we;
  logic              key_re;
  logic              tab_re;
  logic [KEY_W-1:0]  key_rdata;
  logic [BYTE_W-1:0] tab_rdata;
  logic              mod_start;
  logic [DW-1:0]     mod_dvd;
  logic [DW-1:0]     mod_dvs;
  logic [DW-1:0]     mod_rem;
  logic              mod_done;
  logic [DW-1:0]     kpos_inc;
  logic [DW-1:0]     tpos_inc;
  logic [KEY_W-1:0]  klen_raw;
  logic [TLEN_W-1:0] tlen_raw;
  logic [DW-1:0]     klen_eff;
  logic [DW-1:0]     tlen_eff;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign addr_ext   = 32'(entry_address_i);
  assign key_we     = in_acc && (cmd_e'(command_i) == CMD_KEY_WR) && (addr_ext < KEY_DEPTH);
  assign tab_we     = in_acc && (cmd_e'(command_i) == CMD_TABLE_WR) && (addr_ext < TABLE_DEPTH);

  assign klen_raw = cfg_data_i[KEY_W-1:0];
  assign tlen_raw = cfg_data_i[TLEN_W-1:0];

  always_comb begin
    if (klen_raw == '0) begin
      klen_eff = DW'(1);
    end else if (32'(klen_raw) > KEY_DEPTH) begin
      klen_eff = DW'(KEY_DEPTH);
    end else begin
      klen_eff = DW'(klen_raw);
    end
    if (tlen_raw == '0) begin
      tlen_eff = DW'(1);
    end else if (32'(tlen_raw) > TABLE_DEPTH) begin
      tlen_eff = DW'(TABLE_DEPTH);
    end else begin
      tlen_eff = DW'(tlen_raw);
    end
  end

  tkx_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (addr_ext[KAW-1:0]),
    .wdata_i (byte_value_i[KEY_W-1:0]),
    .re_i    (key_re),
    .raddr_i (mod_rem[KAW-1:0]),
    .rdata_o (key_rdata)
  );

  tkx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (addr_ext[TAW-1:0]),
    .wdata_i (byte_value_i),
    .re_i    (tab_re),
    .raddr_i (mod_rem[TAW-1:0]),
    .rdata_o (tab_rdata)
  );

  tkx_mod_unit #(
    .W (DW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (mod_dvs),
    .rem_o      (mod_rem),
    .done_o     (mod_done)
  );

  always_comb begin
    mod_start = 1'b0;
    mod_dvd   = DW'(key_pos_q);
    mod_dvs   = klen_q;
    key_re    = 1'b0;
    tab_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_e'(command_i) == CMD_DATA)) begin
          mod_start = 1'b1;
        end
      end
      ST_KMOD: begin
        if (mod_done) begin
          key_re    = 1'b1;
          mod_start = 1'b1;
          mod_dvd   = DW'(table_pos_q);
          mod_dvs   = tlen_q;
        end
      end
      ST_TMOD: begin
        if (mod_done) begin
          mod_start = 1'b1;
          mod_dvd   = DW'(key_rdata) + mod_rem;
          mod_dvs   = tlen_q;
        end
      end
      ST_AMOD: begin
        tab_re = mod_done;
      end
      default: begin
      end
    endcase
  end

  assign kpos_inc = DW'(kpos_q) + DW'(1);
  assign tpos_inc = DW'(tpos_q) + DW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_pos_q   <= '0;
      table_pos_q <= '0;
      klen_q      <= DW'(1);
      tlen_q      <= DW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_LENGTH:   klen_q <= klen_eff;
          CFG_TABLE_LENGTH: tlen_q <= tlen_eff;
          default: begin
          end
        endcase
      end
      if (out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (cmd_e'(command_i))
              CMD_DATA:    state_q <= ST_KMOD;
              CMD_RESTART: begin
                key_pos_q   <= '0;
                table_pos_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_KMOD: begin
          if (mod_done) state_q <= ST_TMOD;
        end
        ST_TMOD: begin
          if (mod_done) state_q <= ST_AMOD;
        end
        ST_AMOD: begin
          if (mod_done) state_q <= ST_TRD;
        end
        ST_TRD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            key_pos_q   <= (kpos_inc >= klen_q) ? '0 : kpos_inc[KAW-1:0];
            table_pos_q <= (tpos_inc >= tlen_q) ? '0 : tpos_inc[TAW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q <= byte_value_i;
    end
    if ((state_q == ST_KMOD) && mod_done) begin
      kpos_q <= mod_rem[KAW-1:0];
    end
    if ((state_q == ST_TMOD) && mod_done) begin
      tpos_q <= mod_rem[TAW-1:0];
    end
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      cipher_q <= val_q ^ tab_rdata ^ {1'b0, key_rdata};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;

endmodule

### hdl/tkx_checker.sv
// Port-level checker for the table keyed XOR stream cipher, with its bind
`include "table_keyed_xor_stream_cipher_macros.svh"

module tkx_checker
  import tkx_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        command_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] cipher_byte_o
);

  `TKX_ASSERT_NXT(a_data_busy, in_valid_i && in_ready_o && (command_i == CMD_DATA), !in_ready_o, "data beat did not drop ready")
  `TKX_ASSERT_NXT(a_ctrl_quick, in_valid_i && in_ready_o && (command_i != CMD_DATA), in_ready_o, "control beat did not finish in one cycle")
  `TKX_ASSERT_IMP(a_out_after_work, $rose(out_valid_o), !$past(in_ready_o), "result appeared without work")
  `TKX_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cipher_byte_o), "stalled result changed")

endmodule

bind table_keyed_xor_stream_cipher tkx_checker u_tkx_checker (.*);

### sim/table_keyed_xor_stream_cipher_tb.sv
// Self-checking testbench for the table keyed XOR stream cipher: directed and random beats
module table_keyed_xor_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tkx_pkg::*;

  localparam int KEY_DEPTH     = 64;
  localparam int TABLE_DEPTH   = 4096;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 200;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [1:0]        command_i       = CMD_DATA;
  logic [ADDR_W-1:0] entry_address_i = '0;
  logic [BYTE_W-1:0] byte_value_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [BYTE_W-1:0] cipher_byte_o;
  logic              cfg_we_i        = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i       = CFG_KEY_LENGTH;
  logic [CFG_W-1:0]  cfg_data_i      = '0;

  logic [KEY_W-1:0]  key_mem [KEY_DEPTH];
  bit                key_set [KEY_DEPTH];
  logic [BYTE_W-1:0] tbl_mem [TABLE_DEPTH];
  bit                tbl_set [TABLE_DEPTH];
  int unsigned       key_pos = 0;
  int unsigned       tbl_pos = 0;
  logic [KEY_W-1:0]  key_len_q = 7'd1;
  logic [TLEN_W-1:0] tbl_len_q = 13'd1;
  logic [BYTE_W-1:0] cipher_q [$];
  logic [BYTE_W-1:0] want_byte;
  int unsigned       fail_cnt = 0;
  int unsigned       quiet_cycles = 0;
  bit                burst_mode = 1'b0;

  table_keyed_xor_stream_cipher #(
    .KEY_DEPTH  (KEY_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_address_i(entry_address_i),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_byte_o  (cipher_byte_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial forever #2 clk_i = ~clk_i;

  function automatic int unsigned active_len(int unsigned v, int unsigned depth);
    if (v == 0) return 1;
    if (v > depth) return depth;
    return v;
  endfunction

  function automatic void cipher_predict(cmd_e cmd, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] val);
    int unsigned       klen;
    int unsigned       tlen;
    int unsigned       kpos;
    int unsigned       tpos;
    logic [KEY_W-1:0]  k;
    logic [BYTE_W-1:0] t;
    klen = active_len(key_len_q, KEY_DEPTH);
    tlen = active_len(tbl_len_q, TABLE_DEPTH);
    case (cmd)
      CMD_KEY_WR: begin
        if (addr < KEY_DEPTH) begin
          key_mem[addr] = val[KEY_W-1:0];
          key_set[addr] = 1'b1;
        end
      end
      CMD_TABLE_WR: begin
        if (addr < TABLE_DEPTH) begin
          tbl_mem[addr] = val;
          tbl_set[addr] = 1'b1;
        end
      end
      CMD_RESTART: begin
        key_pos = 0;
        tbl_pos = 0;
      end
      default: begin
        kpos = key_pos % klen;
        tpos = tbl_pos % tlen;
        k    = key_mem[kpos];
        t    = tbl_mem[(k + tpos) % tlen];
        cipher_q.push_back(val ^ t ^ {1'b0, k});
        key_pos = (kpos + 1 >= klen) ? 0 : kpos + 1;
        tbl_pos = (tpos + 1 >= tlen) ? 0 : tpos + 1;
      end
    endcase
  endfunction

  task automatic send_beat(cmd_e cmd, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] val);
    @(negedge clk_i);
    while (!burst_mode && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    entry_address_i <= addr;
    byte_value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    cipher_predict(cmd, addr, val);
  endtask

  // load the key and table entries this byte will read if they were never written
  task automatic send_data(logic [BYTE_W-1:0] val);
    int unsigned kslot;
    int unsigned tslot;
    int unsigned tlen;
    kslot = key_pos % active_len(key_len_q, KEY_DEPTH);
    if (!key_set[kslot]) send_beat(CMD_KEY_WR, kslot, $urandom);
    tlen  = active_len(tbl_len_q, TABLE_DEPTH);
    tslot = (key_mem[kslot] + tbl_pos % tlen) % tlen;
    if (!tbl_set[tslot]) send_beat(CMD_TABLE_WR, tslot, $urandom);
    send_beat(CMD_DATA, $urandom, val);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_lengths(logic [CFG_W-1:0] klen, logic [CFG_W-1:0] tlen);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_KEY_LENGTH;
    cfg_data_i <= klen;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TABLE_LENGTH;
    cfg_data_i <= tlen;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    key_len_q = klen[KEY_W-1:0];
    tbl_len_q = tlen;
  endtask

  task automatic send_mixed(int unsigned n);
    int unsigned pick;
    int unsigned tlen;
    repeat (n) begin
      pick = $urandom_range(99);
      tlen = active_len(tbl_len_q, TABLE_DEPTH);
      if (pick < 70)
        send_data($urandom);
      else if (pick < 80)
        send_beat(CMD_KEY_WR, pick[0] ? $urandom_range(KEY_DEPTH - 1) : $urandom, $urandom);
      else if (pick < 92)
        send_beat(CMD_TABLE_WR, pick[0] ? $urandom_range(tlen - 1) : $urandom, $urandom);
      else
        send_beat(CMD_RESTART, $urandom, $urandom);
    end
  endtask

  task automatic test_reset_lengths();
    send_beat(CMD_KEY_WR, 12'd0, 8'hFF);
    send_beat(CMD_TABLE_WR, 12'd0, 8'h00);
    send_data(8'h00);
    send_data(8'hFF);
    send_beat(CMD_KEY_WR, 12'd64, 8'h11);
    send_beat(CMD_KEY_WR, 12'hFFF, 8'h22);
    send_data(8'h5A);
    send_beat(CMD_TABLE_WR, 12'd0, 8'hFF);
    send_data(8'h00);
  endtask

  task automatic test_commands();
    set_lengths(13'd64, 13'd4096);
    send_beat(CMD_TABLE_WR, 12'hFFF, 8'h80);
    send_beat(CMD_KEY_WR, 12'd63, 8'h7F);
    send_beat(CMD_KEY_WR, 12'd0, 8'h00);
    send_data(8'h00);
    send_data(8'hFF);
    send_beat(CMD_RESTART, 12'hFFF, 8'hFF);
    send_data(8'h01);
    send_data(8'h80);
    send_beat(CMD_RESTART, 12'h000, 8'h00);
    send_data(8'hAA);
  endtask

  task automatic test_length_extremes();
    logic [CFG_W-1:0] klens [6];
    logic [CFG_W-1:0] tlens [6];
    klens = '{13'd0, 13'd127, 13'd65, 13'h0085, 13'd64, 13'd1};
    tlens = '{13'd0, 13'h1FFF, 13'd4097, 13'd4095, 13'd4096, 13'd1};
    for (int i = 0; i < 6; i++) begin
      set_lengths(klens[i], tlens[i]);
      repeat (8) send_data($urandom);
    end
  endtask

  task automatic test_length_change_mid_stream();
    set_lengths(13'd10, 13'd300);
    send_beat(CMD_RESTART, $urandom, $urandom);
    repeat (20) send_data($urandom);
    set_lengths(13'd3, 13'd7);
    repeat (20) send_data($urandom);
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] klen;
    logic [CFG_W-1:0] tlen;
    repeat (6) begin
      case ($urandom_range(3))
        0:       klen = 13'd1;
        1:       klen = 13'd64;
        2:       klen = $urandom_range(127);
        default: klen = $urandom_range(1, 8);
      endcase
      case ($urandom_range(4))
        0:       tlen = 13'd1;
        1:       tlen = 13'd4096;
        2:       tlen = $urandom_range(8191);
        3:       tlen = $urandom_range(1, 40);
        default: tlen = $urandom_range(1, 300);
      endcase
      set_lengths(klen, tlen);
      send_mixed(100);
    end
  endtask

  task automatic test_back_to_back();
    set_lengths($urandom_range(1, 64), $urandom_range(1, 64));
    burst_mode = 1'b1;
    send_mixed(120);
    quiesce();
    burst_mode = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= burst_mode || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        $error("cipher_byte: no result pending, actual %02h", cipher_byte_o);
        fail_cnt++;
      end else begin
        want_byte = cipher_q.pop_front();
        if (cipher_byte_o !== want_byte) begin
          $error("cipher_byte: expected %02h, actual %02h", want_byte, cipher_byte_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_lengths();
    test_commands();
    test_length_extremes();
    test_length_change_mid_stream();
    test_random_phases();
    test_back_to_back();
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && cipher_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### table_keyed_xor_stream_cipher.f
+incdir+hdl
hdl/tkx_pkg.sv
hdl/tkx_ram.sv
hdl/tkx_mod_unit.sv
hdl/table_keyed_xor_stream_cipher.sv
hdl/tkx_checker.sv
sim/table_keyed_xor_stream_cipher_tb.sv
